[design/sgcw_pkg.sv]
// shared widths and types for the segment grid cell walker
package sgcw_pkg;

    localparam int COORD_W = 24;
    localparam int SIZE_W  = 16;
    localparam int DIV_W   = 25;
    localparam int PROD_W  = 40;
    localparam int ERR_W   = 48;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd1024;

    localparam logic CFG_CELL_WIDTH = 1'b0;
    localparam logic CFG_CELL_DEPTH = 1'b1;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quo;
        logic [SIZE_W-1:0] rem;
    } div_res_t;

endpackage

[design/sgcw_div.sv]
// restoring unsigned divider, one quotient bit per cycle
module sgcw_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sgcw_pkg::DIV_W-1:0]    dividend,
    input  logic [sgcw_pkg::SIZE_W-1:0]   divisor,
    output sgcw_pkg::div_res_t            res
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [4:0]                    cnt_reg;
    logic [sgcw_pkg::SIZE_W-1:0]   rem_reg;
    logic [sgcw_pkg::DIV_W-1:0]    quo_reg;
    logic [sgcw_pkg::SIZE_W:0]     shifted;
    logic [sgcw_pkg::SIZE_W+1:0]   diff;
    logic                          fits;

    assign shifted = {rem_reg, quo_reg[sgcw_pkg::DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor};
    assign fits    = !diff[sgcw_pkg::SIZE_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[sgcw_pkg::SIZE_W-1:0] : shifted[sgcw_pkg::SIZE_W-1:0];
            quo_reg <= {quo_reg[sgcw_pkg::DIV_W-2:0], fits};
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(sgcw_pkg::DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;
    assign res.rem  = rem_reg;

endmodule

[design/segment_grid_cell_walker.sv]
// segment grid cell walker top level: sequencer, serial multiplier, output register
// sequence: setup is one divide and two multiplies, then each major-axis step is a divide,
// a multiply, a check and an emit, plus one more emit for an extra corner word; the emits
// wait while the receiver stalls
// one segment at a time: a new segment is taken only once the last one's walk is done,
// as the serial divider and shift-add multiplier are shared by all steps
// rst_n is asynchronous active low; cell sizes reset to 1024, walker goes idle
module segment_grid_cell_walker #(
    parameter int MAX_STEPS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // segment channel
    input  logic                                seg_valid,
    output logic                                seg_stall,
    input  logic signed [sgcw_pkg::COORD_W-1:0] start_x,
    input  logic signed [sgcw_pkg::COORD_W-1:0] start_z,
    input  logic signed [sgcw_pkg::COORD_W-1:0] end_x,
    input  logic signed [sgcw_pkg::COORD_W-1:0] end_z,
    // cell channel
    output logic                                cell_valid,
    input  logic                                cell_stall,
    output logic signed [sgcw_pkg::COORD_W-1:0] cell_x,
    output logic signed [sgcw_pkg::COORD_W-1:0] cell_z,
    output logic                                last,
    output logic                                aborted,
    // configuration
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [sgcw_pkg::SIZE_W-1:0]         cfg_data
);

    localparam int CW    = sgcw_pkg::COORD_W;
    localparam int SW    = sgcw_pkg::SIZE_W;
    localparam int ITER_W = $clog2(MAX_STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIVV, S_MULE, S_MULT, S_DIVU, S_MULA, S_CHECK, S_EMIT1, S_EMIT2
    } state_t;

    state_t state_reg;

    // configuration
    logic [SW-1:0] cell_width_reg, cell_depth_reg;
    logic [SW-1:0] wx, wz;
    assign wx = (cell_width_reg == '0) ? SW'(1) : cell_width_reg;
    assign wz = (cell_depth_reg == '0) ? SW'(1) : cell_depth_reg;

    // walk state; u is the major axis, v the minor one
    logic              swap_reg, fwd_u_reg, fwd_v_reg;
    logic signed [CW-1:0] u_reg, ue_reg;
    logic [SW-1:0]     su_reg, sv_reg;
    logic [CW-1:0]     du_reg, dv_reg;
    logic [CW-1:0]     cu_reg, cv_reg, cv_first_reg;
    logic [SW-1:0]     add_reg;
    logic [sgcw_pkg::ERR_W-1:0] err_reg, thr_reg;
    logic [ITER_W-1:0] iters_reg;
    logic              extra_reg, fin_reg, abort_reg;

    // divider operand
    logic signed [CW+1:0] div_c_reg;
    logic [SW-1:0]        div_d_reg;
    logic                 div_start_reg;
    logic                 div_neg;
    logic [sgcw_pkg::DIV_W-1:0] div_n;
    sgcw_pkg::div_res_t   div_res;
    logic [CW-1:0]        div_cell;
    logic [SW-1:0]        div_mod;

    assign div_neg  = div_c_reg[CW+1];
    assign div_n    = div_neg ? ~div_c_reg[CW:0] : div_c_reg[CW:0];
    // floor quotient and floor remainder from the magnitude divide
    assign div_cell = div_neg ? ~div_res.quo[CW-1:0] : div_res.quo[CW-1:0];
    assign div_mod  = div_neg ? (div_d_reg - SW'(1) - div_res.rem) : div_res.rem;

    sgcw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_n),
        .divisor  (div_d_reg),
        .res      (div_res)
    );

    // shift-add multiplier, one multiplier bit per cycle
    logic [SW-1:0]               mul_a_reg;
    logic [sgcw_pkg::PROD_W-1:0] mul_b_reg, mul_acc_reg, mul_prod;
    logic [3:0]                  mul_cnt_reg;
    logic                        mul_last;
    assign mul_prod = mul_acc_reg + (mul_a_reg[0] ? mul_b_reg : '0);
    assign mul_last = (mul_cnt_reg == 4'(SW - 1));

    // segment setup
    logic signed [CW:0] sx, sz, ex, ez, ddx, ddz;
    logic [CW-1:0]      dx, dz;
    logic               in_swap;
    logic signed [CW-1:0] in_v0;
    assign sx  = {start_x[CW-1], start_x};
    assign sz  = {start_z[CW-1], start_z};
    assign ex  = {end_x[CW-1], end_x};
    assign ez  = {end_z[CW-1], end_z};
    assign ddx = ex - sx;
    assign ddz = ez - sz;
    assign dx  = ddx[CW] ? CW'(-ddx) : ddx[CW-1:0];
    assign dz  = ddz[CW] ? CW'(-ddz) : ddz[CW-1:0];
    assign in_swap = dx < dz;
    assign in_v0   = in_swap ? start_x : start_z;

    // next major boundary, clamped to the end point
    logic signed [CW+1:0] u_ext, ue_ext, nxt_raw, nxt, adv;
    assign u_ext   = {{2{u_reg[CW-1]}}, u_reg};
    assign ue_ext  = {{2{ue_reg[CW-1]}}, ue_reg};
    assign nxt_raw = fwd_u_reg ? (u_ext - $signed({10'd0, div_mod}) + $signed({10'd0, su_reg}))
                               : (u_ext - 26'sd1 - $signed({10'd0, div_mod}));
    assign nxt     = fwd_u_reg ? ((nxt_raw > ue_ext) ? ue_ext : nxt_raw)
                               : ((nxt_raw < ue_ext) ? ue_ext : nxt_raw);
    assign adv     = fwd_u_reg ? (nxt - u_ext) : (u_ext - nxt);

    // step decision
    logic                 err_ge, err_gt, walk_done, cap_hit;
    logic signed [CW-1:0] u_new;
    logic [ITER_W-1:0]    iters_inc;
    assign err_ge    = err_reg >= thr_reg;
    assign err_gt    = err_reg > thr_reg;
    assign u_new     = fwd_u_reg ? (u_reg + $signed({8'd0, add_reg}))
                                 : (u_reg - $signed({8'd0, add_reg}));
    assign walk_done = fwd_u_reg ? (u_new >= ue_reg) : (u_new <= ue_reg);
    assign iters_inc = iters_reg + ITER_W'(1);
    assign cap_hit   = iters_inc >= ITER_W'(MAX_STEPS);

    // multiplier operand loads per state
    logic                        mul_load;
    logic [SW-1:0]               mul_a_in;
    logic [sgcw_pkg::PROD_W-1:0] mul_b_in;

    always_comb
    begin
        mul_load = 1'b0;
        mul_a_in = adv[SW-1:0];
        mul_b_in = {16'd0, dv_reg};
        case (state_reg)
            S_DIVV:
            begin
                // error offset from the snapped minor start
                mul_load = div_res.done;
                mul_a_in = fwd_v_reg ? div_mod : (sv_reg - SW'(1) - div_mod);
                mul_b_in = {16'd0, du_reg};
            end
            S_MULE:
            begin
                // threshold
                mul_load = mul_last;
                mul_a_in = sv_reg;
                mul_b_in = {16'd0, du_reg};
            end
            S_DIVU:
            begin
                // error increment for this major advance
                mul_load = div_res.done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_a_reg   <= '0;
            mul_b_reg   <= '0;
            mul_acc_reg <= '0;
            mul_cnt_reg <= '0;
        end
        else if (mul_load)
        begin
            mul_a_reg   <= mul_a_in;
            mul_b_reg   <= mul_b_in;
            mul_acc_reg <= '0;
            mul_cnt_reg <= '0;
        end
        else
        begin
            mul_acc_reg <= mul_prod;
            mul_a_reg   <= mul_a_reg >> 1;
            mul_b_reg   <= mul_b_reg << 1;
            mul_cnt_reg <= mul_cnt_reg + 4'd1;
        end
    end

    // output register
    logic              cell_valid_reg, last_reg, aborted_reg;
    logic [CW-1:0]     cell_x_reg, cell_z_reg;
    logic              out_free;
    logic              emit_go, div_go;
    assign out_free = !cell_valid_reg || !cell_stall;
    assign emit_go  = ((state_reg == S_EMIT1) || (state_reg == S_EMIT2)) && out_free;
    // divider kicks: segment accept, after the threshold, and after each step's words
    assign div_go   = ((state_reg == S_IDLE) && seg_valid)
                   || ((state_reg == S_MULT) && mul_last)
                   || ((state_reg == S_EMIT1) && out_free && !extra_reg && !fin_reg)
                   || ((state_reg == S_EMIT2) && out_free && !fin_reg);

    assign seg_stall  = (state_reg != S_IDLE);
    assign cell_valid = cell_valid_reg;
    assign cell_x     = cell_x_reg;
    assign cell_z     = cell_z_reg;
    assign last       = last_reg;
    assign aborted    = aborted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cell_width_reg <= sgcw_pkg::SIZE_RESET;
            cell_depth_reg <= sgcw_pkg::SIZE_RESET;
            cell_valid_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            iters_reg      <= '0;
        end
        else
        begin
            div_start_reg <= div_go;

            if (cfg_we)
            begin
                case (cfg_index)
                    sgcw_pkg::CFG_CELL_WIDTH: cell_width_reg <= cfg_data;
                    sgcw_pkg::CFG_CELL_DEPTH: cell_depth_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (emit_go)
                cell_valid_reg <= 1'b1;
            else if (cell_valid_reg && !cell_stall)
                cell_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (seg_valid)
                    begin
                        swap_reg      <= in_swap;
                        u_reg         <= in_swap ? start_z : start_x;
                        ue_reg        <= in_swap ? end_z : end_x;
                        fwd_u_reg     <= in_swap ? !ddz[CW] : !ddx[CW];
                        fwd_v_reg     <= in_swap ? !ddx[CW] : !ddz[CW];
                        su_reg        <= in_swap ? wz : wx;
                        sv_reg        <= in_swap ? wx : wz;
                        du_reg        <= in_swap ? dz : dx;
                        dv_reg        <= in_swap ? dx : dz;
                        iters_reg     <= '0;
                        div_c_reg     <= (in_swap ? !ddx[CW] : !ddz[CW])
                                         ? {{2{in_v0[CW-1]}}, in_v0}
                                         : ({{2{in_v0[CW-1]}}, in_v0} - 26'sd1);
                        div_d_reg     <= in_swap ? wx : wz;
                        state_reg     <= S_DIVV;
                    end
                end
                S_DIVV:
                begin
                    if (div_res.done)
                    begin
                        // minor cell of the start point
                        cv_reg      <= div_cell;
                        state_reg   <= S_MULE;
                    end
                end
                S_MULE:
                begin
                    if (mul_last)
                    begin
                        err_reg     <= {8'd0, mul_prod};
                        state_reg   <= S_MULT;
                    end
                end
                S_MULT:
                begin
                    if (mul_last)
                    begin
                        thr_reg       <= {8'd0, mul_prod};
                        div_c_reg     <= fwd_u_reg ? u_ext : (u_ext - 26'sd1);
                        div_d_reg     <= su_reg;
                        state_reg     <= S_DIVU;
                    end
                end
                S_DIVU:
                begin
                    if (div_res.done)
                    begin
                        cu_reg      <= div_cell;
                        add_reg     <= adv[SW-1:0];
                        state_reg   <= S_MULA;
                    end
                end
                S_MULA:
                begin
                    if (mul_last)
                    begin
                        err_reg   <= err_reg + {8'd0, mul_prod};
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    cv_first_reg <= cv_reg;
                    extra_reg    <= err_ge && err_gt;
                    if (err_ge)
                    begin
                        cv_reg  <= fwd_v_reg ? (cv_reg + CW'(1)) : (cv_reg - CW'(1));
                        err_reg <= err_reg - thr_reg;
                    end
                    u_reg     <= u_new;
                    iters_reg <= iters_inc;
                    fin_reg   <= walk_done || cap_hit;
                    abort_reg <= !walk_done && cap_hit;
                    state_reg <= S_EMIT1;
                end
                S_EMIT1:
                begin
                    if (out_free)
                    begin
                        cell_x_reg     <= swap_reg ? cv_first_reg : cu_reg;
                        cell_z_reg     <= swap_reg ? cu_reg : cv_first_reg;
                        last_reg       <= fin_reg && !extra_reg;
                        aborted_reg    <= abort_reg && !extra_reg;
                        if (extra_reg)
                            state_reg <= S_EMIT2;
                        else if (fin_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            div_c_reg     <= fwd_u_reg ? u_ext : (u_ext - 26'sd1);
                            div_d_reg     <= su_reg;
                            state_reg     <= S_DIVU;
                        end
                    end
                end
                S_EMIT2:
                begin
                    if (out_free)
                    begin
                        // extra cell at the stepped minor position
                        cell_x_reg     <= swap_reg ? cv_reg : cu_reg;
                        cell_z_reg     <= swap_reg ? cu_reg : cv_reg;
                        last_reg       <= fin_reg;
                        aborted_reg    <= abort_reg;
                        if (fin_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            div_c_reg     <= fwd_u_reg ? u_ext : (u_ext - 26'sd1);
                            div_d_reg     <= su_reg;
                            state_reg     <= S_DIVU;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sim/sgcw_checker.sv]
// cell stream checker: predicts the cells of each accepted segment and compares them
module sgcw_checker #(
    parameter int MAX_STEPS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                seg_valid,
    input  logic                                seg_stall,
    input  logic signed [sgcw_pkg::COORD_W-1:0] start_x,
    input  logic signed [sgcw_pkg::COORD_W-1:0] start_z,
    input  logic signed [sgcw_pkg::COORD_W-1:0] end_x,
    input  logic signed [sgcw_pkg::COORD_W-1:0] end_z,
    input  logic                                cell_valid,
    input  logic                                cell_stall,
    input  logic signed [sgcw_pkg::COORD_W-1:0] cell_x,
    input  logic signed [sgcw_pkg::COORD_W-1:0] cell_z,
    input  logic                                last,
    input  logic                                aborted,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [sgcw_pkg::SIZE_W-1:0]         cfg_data,
    output int                                  failures,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = sgcw_pkg::COORD_W;
    localparam int SIZE_W  = sgcw_pkg::SIZE_W;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] z;
        logic               fin;
        logic               ab;
    } grid_cell_t;

    grid_cell_t        cells_due[$];
    logic [SIZE_W-1:0] width_q;
    logic [SIZE_W-1:0] depth_q;

    function automatic longint fdiv(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint index_of(longint c, longint sz, bit fwd);
        return fwd ? fdiv(c, sz) : fdiv(c - 1, sz);
    endfunction

    function automatic grid_cell_t place(longint cu, longint cv, bit swap);
        grid_cell_t g;
        g.x   = swap ? cv[COORD_W-1:0] : cu[COORD_W-1:0];
        g.z   = swap ? cu[COORD_W-1:0] : cv[COORD_W-1:0];
        g.fin = 1'b0;
        g.ab  = 1'b0;
        return g;
    endfunction

    // walk one segment along its major axis, queueing every crossed cell
    task automatic walk_segment(input longint sx, input longint sz, input longint ex,
                                input longint ez);
        longint     wx, wz, dx, dz, u0, ue, v0, ve, su, sv, du, dv;
        longint     u, v, err, thr, add, nxt, cu, cv;
        bit         swap, fu, fv, ab;
        int         iters;
        grid_cell_t walk[$];
        grid_cell_t g;
        wx = (width_q == 0) ? 1 : longint'(width_q);
        wz = (depth_q == 0) ? 1 : longint'(depth_q);
        dx = (ex > sx) ? ex - sx : sx - ex;
        dz = (ez > sz) ? ez - sz : sz - ez;
        swap = dx < dz;
        if (swap)
        begin
            u0 = sz; ue = ez; v0 = sx; ve = ex; su = wz; sv = wx; du = dz; dv = dx;
        end
        else
        begin
            u0 = sx; ue = ex; v0 = sz; ve = ez; su = wx; sv = wz; du = dx; dv = dz;
        end
        fu = (ue - u0) >= 0;
        fv = (ve - v0) >= 0;
        u = u0;
        if (!fv)
        begin
            v = fdiv(v0 + sv - 1, sv) * sv;
            err = (v - v0) * du;
        end
        else
        begin
            v = fdiv(v0, sv) * sv;
            err = (v0 - v) * du;
        end
        thr = sv * du;
        ab = 0;
        iters = 0;
        forever
        begin
            cu = index_of(u, su, fu);
            cv = index_of(v, sv, fv);
            walk = {walk, place(cu, cv, swap)};
            if (fu)
            begin
                nxt = fdiv(u + su, su) * su;
                if (nxt > ue) nxt = ue;
                add = nxt - u;
                err = err + add * dv;
            end
            else
            begin
                nxt = fdiv(u - 1, su) * su;
                if (nxt < ue) nxt = ue;
                add = nxt - u;
                err = err - add * dv;
            end
            if (err >= thr)
            begin
                v = fv ? v + sv : v - sv;
                // strictly past the corner: the extra cell is visited too
                if (err > thr)
                    walk = {walk, place(cu, index_of(v, sv, fv), swap)};
                err = err - thr;
            end
            u = u + add;
            if ((fu && u >= ue) || (!fu && u <= ue))
                break;
            iters++;
            if (iters >= MAX_STEPS)
            begin
                ab = 1;
                break;
            end
        end
        g = walk.pop_back();
        g.fin = 1'b1;
        g.ab  = ab;
        walk = {walk, g};
        foreach (walk[i])
            cells_due = {cells_due, walk[i]};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grid_cell_t want;
        if (!rst_n)
        begin
            width_q  <= sgcw_pkg::SIZE_RESET;
            depth_q  <= sgcw_pkg::SIZE_RESET;
            failures <= 0;
            pending  <= 0;
            cells_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == sgcw_pkg::CFG_CELL_WIDTH)
                    width_q <= cfg_data;
                else
                    depth_q <= cfg_data;
            end
            if (seg_valid && !seg_stall)
                walk_segment(start_x, start_z, end_x, end_z);
            if (cell_valid && !cell_stall)
            begin
                if (cells_due.size() == 0)
                begin
                    $error("cell word with nothing expected: x=%0d z=%0d", cell_x, cell_z);
                    failures <= failures + 1;
                end
                else
                begin
                    want = cells_due.pop_front();
                    if (cell_x !== want.x || cell_z !== want.z || last !== want.fin
                        || aborted !== want.ab)
                    begin
                        failures <= failures + 1;
                        if (cell_x !== want.x)
                            $error("cell_x expected %h got %h", want.x, cell_x);
                        if (cell_z !== want.z)
                            $error("cell_z expected %h got %h", want.z, cell_z);
                        if (last !== want.fin)
                            $error("last expected %b got %b", want.fin, last);
                        if (aborted !== want.ab)
                            $error("aborted expected %b got %b", want.ab, aborted);
                    end
                end
            end
            pending <= cells_due.size();
        end
    end

endmodule

[sim/tb.sv]
// testbench top: segment stimulus, configuration phases and verdict for the cell walker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = sgcw_pkg::COORD_W;
    localparam int SIZE_W  = sgcw_pkg::SIZE_W;

    // run limit; a segment walks at most 32 steps and emits at most 64 words, any of them stalled
    localparam int LIMIT = 3000000;
    localparam longint CMAX = 8388607;
    localparam longint CMIN = -8388608;

    logic                      clk;
    logic                      rst_n;
    logic                      seg_valid;
    logic                      seg_stall;
    logic signed [COORD_W-1:0] start_x, start_z, end_x, end_z;
    logic                      cell_valid;
    logic                      cell_stall;
    logic signed [COORD_W-1:0] cell_x, cell_z;
    logic                      last, aborted;
    logic                      cfg_we;
    logic                      cfg_index;
    logic [SIZE_W-1:0]         cfg_data;
    int                        failures;
    int                        pending;
    int                        cycles;
    int                        hold_left;
    bit                        quiet;

    segment_grid_cell_walker #(.MAX_STEPS(32)) DUT (.*);

    sgcw_checker #(.MAX_STEPS(32)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure in random bursts, off once the run goes quiet
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left = hold_left - 1;
        else if (!quiet && $urandom_range(0, 9) == 0)
            hold_left = $urandom_range(1, 18);
        cell_stall <= (hold_left != 0);
    end

    // present one segment word and hold it until the walker takes it
    task automatic send_seg(input longint sx, input longint sz, input longint ex,
                            input longint ez);
        seg_valid <= 1'b1;
        start_x   <= sx[COORD_W-1:0];
        start_z   <= sz[COORD_W-1:0];
        end_x     <= ex[COORD_W-1:0];
        end_z     <= ez[COORD_W-1:0];
        do @(posedge clk); while (seg_stall);
        // sender gap burst
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            seg_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // stop sending and let every expected cell drain
    task automatic drain();
        seg_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= sgcw_pkg::CFG_CELL_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= sgcw_pkg::CFG_CELL_DEPTH;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic longint pick_end(longint s, longint sz);
        longint span, e;
        // mostly a few cells, sometimes long enough to hit the step cap
        span = ($urandom_range(0, 15) == 0) ? 48 : $urandom_range(0, 6);
        e = longint'($urandom_range(0, span * sz * 2 + 1)) - span * sz;
        if ($urandom_range(0, 5) == 0)
            e = 0;
        e = s + e;
        if (e > CMAX || e < CMIN)
            e = 2 * s - e;
        if (e > CMAX) e = CMAX;
        if (e < CMIN) e = CMIN;
        return e;
    endfunction

    task automatic random_segs(input int count, input longint w, input longint d);
        longint sx, sz;
        repeat (count)
        begin
            sx = longint'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
            sz = longint'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
            send_seg(sx, sz, pick_end(sx, w), pick_end(sz, d));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        seg_valid  = 1'b0;
        start_x    = '0;
        start_z    = '0;
        end_x      = '0;
        end_z      = '0;
        cfg_we     = 1'b0;
        cfg_index  = sgcw_pkg::CFG_CELL_WIDTH;
        cfg_data   = '0;
        quiet      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset cell sizes
        send_seg(100, 200, 100, 200);              // single point
        send_seg(0, 0, 2048, 2048);                // diagonal through exact corners
        send_seg(0, 0, -2048, -2048);              // same, walking backward
        send_seg(10, 20, 5000, 1700);              // x major, minor crosses past corner
        send_seg(10, 20, 1700, 5000);              // z major
        send_seg(-3000, 500, -3000, -4000);        // pure z, backward
        send_seg(-5000, 7, 3000, 7);               // pure x, forward
        send_seg(4096, 4096, 0, 1024);             // both backward
        send_seg(-1, -1, 1, 1);                    // straddles zero
        send_seg(CMAX, CMAX, CMAX - 3000, CMIN);   // coordinate extremes
        send_seg(CMIN, CMIN, CMIN + 5000, CMAX);
        send_seg(0, 0, 200000, 3);                 // step cap reached
        random_segs(20, 1024, 1024);

        // unit cells: index wrap at the negative edge, caps come quickly
        drain();
        set_sizes(16'd1, 16'd1);
        send_seg(CMIN + 8, CMIN + 3, CMIN, CMIN);
        send_seg(CMAX, 0, CMAX - 40, 40);
        send_seg(0, 0, 5, 3);
        random_segs(40, 1, 1);

        // largest cells
        drain();
        set_sizes(16'hFFFF, 16'hFFFF);
        send_seg(CMIN, CMIN, CMAX, CMAX);
        send_seg(65535, -65535, -65536, 65536);
        random_segs(40, 65535, 65535);

        // unequal sizes and a zero size treated as one
        drain();
        set_sizes(16'd3, 16'd700);
        random_segs(40, 3, 700);
        drain();
        set_sizes(16'd0, 16'd37);
        send_seg(0, 0, 20, 20);
        random_segs(40, 1, 37);

        // last stretch with no idling on either side
        drain();
        set_sizes(16'd1000, 16'd999);
        quiet = 1;
        random_segs(30, 1000, 999);

        drain();
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/sgcw_pkg.sv
design/sgcw_div.sv
design/segment_grid_cell_walker.sv
sim/sgcw_checker.sv
sim/tb.sv
